@@ rtl/sha1_pkg.sv @@
// Shared types and constants for the SHA-1 digest block.
package sha1_pkg;

	// Source of the word shifted into the block buffer
	localparam logic [2:0] SRC_IN     = 3'd0;
	localparam logic [2:0] SRC_PAD    = 3'd1;
	localparam logic [2:0] SRC_ZERO   = 3'd2;
	localparam logic [2:0] SRC_LEN_HI = 3'd3;
	localparam logic [2:0] SRC_LEN_LO = 3'd4;

	// Round bookkeeping
	localparam logic [6:0] ROUND_LAST = 7'd79;
	localparam logic [6:0] ROUND_F1   = 7'd20;
	localparam logic [6:0] ROUND_F2   = 7'd40;
	localparam logic [6:0] ROUND_F3   = 7'd60;

	// Round constants
	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	// Initial hash values
	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hefcdab89;
	localparam logic [31:0] H2_INIT = 32'h98badcfe;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

	// Padding marker word
	localparam logic [31:0] PAD_WORD = 32'h80000000;

	localparam logic [2:0] LAST_DIGEST_IDX = 3'd4;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       push;      // shift a word into the block buffer
		logic [2:0] src;       // which word to shift in
		logic       count_en;  // add the accepted beat to the bit count
		logic       init_wv;   // load working variables from the hash
		logic       round_en;  // run one compression round
		logic [6:0] round;     // round number 0..79
		logic       add_hash;  // fold working variables into the hash
		logic       clear;     // restore initial hash and zero the count
		logic [2:0] out_idx;   // digest word on the output
	} sha1_cmd_t;

endpackage

@@ rtl/sha1_ctrl.sv @@
// Controller: sequencing of word loads, padding, rounds and digest beats.
module sha1_ctrl
	import sha1_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       s_tlast,
	input  logic [2:0] s_tuser,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic       m_tlast,
	output logic [2:0] m_tuser,
	output sha1_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_LENLO = 3'd2;
	localparam logic [2:0] ST_COMP  = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [3:0] POS_LEN  = 4'd14;
	localparam logic [3:0] POS_FULL = 4'd15;

	logic [2:0] state_q, state_d;
	logic [2:0] ret_q, ret_d;
	logic [3:0] pos_q;
	logic [6:0] round_q, round_d;
	logic [2:0] idx_q, idx_d;
	logic       pad80_q, pad80_d;
	logic       in_beat;

	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tuser  = idx_q;
	assign m_tlast  = (idx_q == LAST_DIGEST_IDX);

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		ret_d        = ret_q;
		round_d      = round_q;
		idx_d        = idx_q;
		pad80_d      = pad80_q;
		cmd          = '0;
		cmd.src      = SRC_IN;
		cmd.round    = round_q;
		cmd.out_idx  = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					cmd.push     = 1'b1;
					cmd.count_en = 1'b1;
					if (s_tlast) begin
						pad80_d = (s_tuser >= 3'd4);
						ret_d   = ST_PAD;
						state_d = ST_PAD;
					end else begin
						ret_d = ST_IDLE;
					end
					if (pos_q == POS_FULL) begin
						state_d = ST_COMP;
					end
				end
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				ret_d    = ST_PAD;
				if (pad80_q) begin
					cmd.src = SRC_PAD;
					pad80_d = 1'b0;
				end else if (pos_q == POS_LEN) begin
					cmd.src = SRC_LEN_HI;
					state_d = ST_LENLO;
				end else begin
					cmd.src = SRC_ZERO;
				end
				if (pos_q == POS_FULL) begin
					state_d = ST_COMP;
				end
			end
			ST_LENLO: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_LEN_LO;
				ret_d    = ST_OUT;
				state_d  = ST_COMP;
			end
			ST_COMP: begin
				cmd.round_en = 1'b1;
				if (round_q == ROUND_LAST) begin
					round_d = '0;
					state_d = ST_ADD;
				end else begin
					round_d = round_q + 7'd1;
				end
			end
			ST_ADD: begin
				cmd.add_hash = 1'b1;
				state_d      = ret_q;
			end
			ST_OUT: begin
				if (m_tready) begin
					if (idx_q == LAST_DIGEST_IDX) begin
						cmd.clear = 1'b1;
						idx_d     = '0;
						state_d   = ST_IDLE;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// Load working variables as the sixteenth word of a block goes in
		cmd.init_wv = cmd.push && (pos_q == POS_FULL);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			pos_q   <= '0;
			round_q <= '0;
			idx_q   <= '0;
			pad80_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			round_q <= round_d;
			idx_q   <= idx_d;
			pad80_q <= pad80_d;
			if (cmd.push) begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

endmodule

@@ rtl/sha1_dp.sv @@
// Datapath: block buffer, message schedule, round unit, hash and bit count.
module sha1_dp
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        s_tlast,
	input  sha1_cmd_t   cmd,
	output logic [31:0] m_tdata
);

	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [63:0] bits_q;

	logic [31:0] in_word, push_word, sched_x, sched_word, f_val, k_val, t_val;
	logic [6:0]  bits_inc;

	// Trim and pad the incoming beat
	always_comb begin
		in_word  = s_tdata;
		bits_inc = 7'd32;
		if (s_tlast) begin
			case (s_tuser)
				3'd0: begin
					in_word  = PAD_WORD;
					bits_inc = 7'd0;
				end
				3'd1: begin
					in_word  = {s_tdata[31:24], 24'h800000};
					bits_inc = 7'd8;
				end
				3'd2: begin
					in_word  = {s_tdata[31:16], 16'h8000};
					bits_inc = 7'd16;
				end
				3'd3: begin
					in_word  = {s_tdata[31:8], 8'h80};
					bits_inc = 7'd24;
				end
				default: begin
					in_word  = s_tdata;
					bits_inc = 7'd32;
				end
			endcase
		end
	end

	// Select the word entering the buffer
	always_comb begin
		case (cmd.src)
			SRC_IN:     push_word = in_word;
			SRC_PAD:    push_word = PAD_WORD;
			SRC_LEN_HI: push_word = bits_q[63:32];
			SRC_LEN_LO: push_word = bits_q[31:0];
			default:    push_word = '0;
		endcase
	end

	// Schedule: w_q[0] is the word of the current round
	assign sched_x    = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign sched_word = {sched_x[30:0], sched_x[31]};

	// Round function and constant
	always_comb begin
		if (cmd.round < ROUND_F1) begin
			f_val = (b_q & c_q) ^ (~b_q & d_q);
			k_val = K0;
		end else if (cmd.round < ROUND_F2) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K1;
		end else if (cmd.round < ROUND_F3) begin
			f_val = (b_q & c_q) ^ (b_q & d_q) ^ (c_q & d_q);
			k_val = K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K3;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_q[0];

	// Shift the buffer on a load or a round
	always_ff @(posedge clk) begin
		if (cmd.push || cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= cmd.push ? push_word : sched_word;
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (cmd.init_wv) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round_en) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// Chaining hash and bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= H0_INIT;
			h_q[1] <= H1_INIT;
			h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT;
			h_q[4] <= H4_INIT;
			bits_q <= '0;
		end else if (cmd.clear) begin
			h_q[0] <= H0_INIT;
			h_q[1] <= H1_INIT;
			h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT;
			h_q[4] <= H4_INIT;
			bits_q <= '0;
		end else begin
			if (cmd.add_hash) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (cmd.count_en) begin
				bits_q <= bits_q + {57'd0, bits_inc};
			end
		end
	end

	// Digest word out
	always_comb begin
		case (cmd.out_idx)
			3'd0:    m_tdata = h_q[0];
			3'd1:    m_tdata = h_q[1];
			3'd2:    m_tdata = h_q[2];
			3'd3:    m_tdata = h_q[3];
			default: m_tdata = h_q[4];
		endcase
	end

endmodule

@@ rtl/sha1_digest.sv @@
// Top level of the SHA-1 digest block: controller and datapath.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  data_word, valid_bytes, end_of_message
//  m_*      out  m_tvalid/m_tready  digest_word, word_index, final_word
//
// Each sixteenth word starts 80 rounds plus a hash add, all run by the
// single shared round unit, before the next word is taken. The final beat
// adds one padding word after another (up to 18, with a second compression
// when the length no longer fits) and then five digest beats.
// Input is not taken during rounds, padding or digest output.
// Reset loads the initial hash and zeroes the bit count at once; digest beats
// hold while m_tready is low.
module sha1_digest
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] data_word
	input  logic [2:0]  s_tuser,   // [2:0] valid_bytes
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast    // final_word
);

	sha1_cmd_t cmd;

	sha1_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cmd      (cmd)
	);

	sha1_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.cmd     (cmd),
		.m_tdata (m_tdata)
	);

endmodule
